// ===== hdl/alu_acc_pkg.sv =====
// ----------------------------------------------------------------------------
// alu_acc_pkg: shared types, opcodes and helpers for the accumulator ALU
// Holds the request beat layout, the opcode set and the leading-zero count.
// ----------------------------------------------------------------------------
package alu_acc_pkg;

   localparam int KIND_W = 12;
   localparam int DATA_W = 32;
   localparam int OP_W   = 4;
   localparam int SHAMT_W = 5;
   localparam int CLZ_W  = 6;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 4'd0,
      OP_SUB_AB = 4'd1,
      OP_SUB_BA = 4'd2,
      OP_MUL    = 4'd3,
      OP_MAC    = 4'b0100,
      OP_EQ     = 4'd5,
      OP_SHL    = 4'd6,
      OP_SHR    = 4'd7,
      OP_AND    = 4'd8,
      OP_OR     = 4'd9,
      OP_XOR    = 4'd10,
      OP_ANDN   = 4'd11,
      OP_PASS_A = 4'd12,
      OP_CLZ    = 4'b1101,
      OP_STORE  = 4'b1110,
      OP_RECALL = 4'b1111
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic [DATA_W-1:0] store_value;
   } req_type;

   // Leading zeros by halving search; all-zero input gives 32.
   function automatic logic [CLZ_W-1:0] clz32(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] x;
      logic [CLZ_W-1:0]  n;
      x = v;
      n = '0;
      if (x[31:16] == 16'd0) begin
         n = n + CLZ_W'(16);
         x = x << 16;
      end
      if (x[31:24] == 8'd0) begin
         n = n + CLZ_W'(8);
         x = x << 8;
      end
      if (x[31:28] == 4'd0) begin
         n = n + CLZ_W'(4);
         x = x << 4;
      end
      if (x[31:30] == 2'd0) begin
         n = n + CLZ_W'(2);
         x = x << 2;
      end
      if (x[31] == 1'b0) begin
         n = n + CLZ_W'(1);
         x = x << 1;
      end
      if (x[31] == 1'b0) begin
         n = n + CLZ_W'(1);
      end
      return n;
   endfunction

endpackage

// ===== hdl/alu_acc_core.sv =====
// ----------------------------------------------------------------------------
// alu_acc_core: operation datapath and accumulator register
// Computes one result per beat; the accumulator updates when fire is high.
// ----------------------------------------------------------------------------
module alu_acc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  alu_acc_pkg::req_type       req,
   output logic [alu_acc_pkg::DATA_W-1:0] result
);
   import alu_acc_pkg::*;

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;
   logic [DATA_W-1:0] product;
   logic [DATA_W-1:0] mac_sum;
   logic              big_shift;
   logic [SHAMT_W-1:0] shamt;
   logic              kind_defined;
   op_type            op;

   assign product      = req.operand_a * req.operand_b;
   assign mac_sum      = acc_ff + product;
   assign big_shift    = |req.operand_b[DATA_W-1:SHAMT_W];
   assign shamt        = req.operand_b[SHAMT_W-1:0];
   assign kind_defined = (req.kind[KIND_W-1:OP_W] == '0);
   assign op           = op_type'(req.kind[OP_W-1:0]);

   always_comb begin
      result = '0;
      acc_in = acc_ff;
      if (kind_defined) begin
         case (op)
            OP_ADD:    result = req.operand_a + req.operand_b;
            OP_SUB_AB: result = req.operand_a - req.operand_b;
            OP_SUB_BA: result = req.operand_b - req.operand_a;
            OP_MUL:    result = product;
            OP_MAC: begin
               result = mac_sum;
               acc_in = mac_sum;
            end
            OP_EQ:     result = DATA_W'(req.operand_a == req.operand_b);
            OP_SHL:    result = big_shift ? '0 : (req.operand_a << shamt);
            OP_SHR:    result = big_shift ? '0 : (req.operand_a >> shamt);
            OP_AND:    result = req.operand_a & req.operand_b;
            OP_OR:     result = req.operand_a | req.operand_b;
            OP_XOR:    result = req.operand_a ^ req.operand_b;
            OP_ANDN:   result = req.operand_a & ~req.operand_b;
            OP_PASS_A: result = req.operand_a;
            OP_CLZ:    result = DATA_W'(clz32(req.operand_a));
            OP_STORE: begin
               result = req.store_value;
               acc_in = req.store_value;
            end
            OP_RECALL: result = acc_ff;
            default:   result = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (fire) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== hdl/alu_with_accumulator.sv =====
// ----------------------------------------------------------------------------
// alu_with_accumulator: 32-bit integer ALU with a kept accumulator
// Usage:
//   Request beats (req_*) carry an opcode, two operands and a store value.
//   Each request beat gives exactly one response beat (rsp_result), in order.
//   A beat moves when valid is high and stall is low on its channel.
// Path: a request beat is held in the input register, then in the result
//   register, from which it is offered on rsp_*.
// Throughput: one beat per clock while rsp_stall is low; the datapath
//   (32x32 multiply plus accumulator add) is combinational between the two registers.
// Stall: when rsp_stall holds a pending response, the input register still
//   takes one more beat; req_stall rises only when both registers are full
//   and the response is stalled. A stalled response holds its value.
// Reset: synchronous, active high; clears both valid flags and sets the
//   accumulator to zero. Opcodes above 15 return zero and leave it alone.
// ----------------------------------------------------------------------------
module alu_with_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [alu_acc_pkg::KIND_W-1:0]     req_kind,
   input  logic [alu_acc_pkg::DATA_W-1:0]     req_operand_a,
   input  logic [alu_acc_pkg::DATA_W-1:0]     req_operand_b,
   input  logic [alu_acc_pkg::DATA_W-1:0]     req_store_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [alu_acc_pkg::DATA_W-1:0]     rsp_result
);
   import alu_acc_pkg::*;

   // input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_ff;
   // result stage
   logic              res_valid_ff;
   logic              res_valid_in;
   logic [DATA_W-1:0] res_ff;
   logic [DATA_W-1:0] res_in;

   logic              res_load;   // result register free this cycle
   logic              req_accept; // request beat taken
   logic              fire;       // input stage moves to result stage

   assign res_load   = !res_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !res_load;
   assign req_accept = req_valid && !req_stall;
   assign fire       = in_valid_ff && res_load;

   assign in_valid_in  = req_accept || (in_valid_ff && !res_load);
   assign res_valid_in = fire || (res_valid_ff && rsp_stall);

   // Accumulator updates at the same edge the beat lands in the result
   // register, so recall always sees every earlier beat.
   alu_acc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (in_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.kind        <= req_kind;
         in_ff.operand_a   <= req_operand_a;
         in_ff.operand_b   <= req_operand_b;
         in_ff.store_value <= req_store_value;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid  = res_valid_ff;
   assign rsp_result = res_ff;

endmodule
